FILE: rtl/sacf_pkg.sv
// shared types, constants and codes for the set-associative fifo cache tracker
`default_nettype none
package sacf_pkg;

	localparam int SET_COUNT  = 256;
	localparam int WAYS       = 8;
	localparam int ADDR_BITS  = 48;
	localparam int COUNT_BITS = 32;
	localparam int AGE_BITS   = 4;

	localparam int SET_BITS  = $clog2(SET_COUNT);
	localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int NWAY_BITS = $clog2(WAYS + 1);

	localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

	typedef logic [1:0] cfg_index_t;
	localparam cfg_index_t CFG_OFFSET_BITS = 2'd0;
	localparam cfg_index_t CFG_INDEX_BITS  = 2'd1;
	localparam cfg_index_t CFG_WAYS_USED   = 2'd2;

	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	typedef struct packed {
		logic                 req_type;
		logic [ADDR_BITS-1:0] address;
	} sacf_req_t;

	typedef struct packed {
		logic                  hit;
		logic                  mem_read;
		logic                  mem_write;
		logic [COUNT_BITS-1:0] hit_total;
		logic [COUNT_BITS-1:0] miss_total;
		logic [COUNT_BITS-1:0] read_total;
		logic [COUNT_BITS-1:0] write_total;
	} sacf_rsp_t;

	// one set: valid, fill age and tag of every way
	typedef struct packed {
		logic [WAYS-1:0]                valid;
		logic [WAYS-1:0][AGE_BITS-1:0]  age;
		logic [WAYS-1:0][ADDR_BITS-1:0] tag;
	} sacf_row_t;

	localparam int ROW_BITS = $bits(sacf_row_t);

	typedef enum logic {
		ST_IDLE,
		ST_LOOKUP
	} sacf_state_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} sacf_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/sacf_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module sacf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule
`default_nettype wire

FILE: rtl/sacf_ctrl.sv
// controller: request sequencing and output word handshake
`default_nettype none
module sacf_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_ready,
	output logic                     rsp_valid,
	input  wire logic                rsp_ready,
	output sacf_pkg::sacf_cmd_t      cmd
);
	import sacf_pkg::*;

	sacf_state_t state_q, state_d;
	logic        rsp_valid_q, rsp_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		req_ready   = 1'b0;
		rsp_valid_d = rsp_valid_q && !rsp_ready;
		unique case (state_q)
			ST_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
				if (req_valid) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				// wait for a free output slot
				if (!rsp_valid_q || rsp_ready) begin
					cmd.commit  = 1'b1;
					rsp_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
endmodule
`default_nettype wire

FILE: rtl/sacf_dp.sv
// datapath: config registers, set memory, tag compare, fifo fill and counters
`default_nettype none
module sacf_dp (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	input  wire sacf_pkg::cfg_index_t  cfg_index,
	input  wire logic [4:0]            cfg_data,
	input  wire sacf_pkg::sacf_req_t   req,
	input  wire sacf_pkg::sacf_cmd_t   cmd,
	output sacf_pkg::sacf_rsp_t        rsp
);
	import sacf_pkg::*;

	localparam logic [3:0] IB_MAX = 4'(SET_BITS);

	logic [4:0] offset_bits_q;
	logic [3:0] index_bits_q;
	logic [3:0] ways_used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_bits_q <= 5'd2;
			index_bits_q  <= 4'd0;
			ways_used_q   <= 4'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_OFFSET_BITS: offset_bits_q <= cfg_data;
				CFG_INDEX_BITS:  index_bits_q  <= cfg_data[3:0];
				CFG_WAYS_USED:   ways_used_q   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// address split
	logic [3:0]           ib_eff;
	logic [5:0]           tag_shift;
	logic [ADDR_BITS-1:0] addr_sh;
	logic [SET_BITS-1:0]  set_mask;
	logic [SET_BITS-1:0]  set_in;
	logic [ADDR_BITS-1:0] tag_in;

	always_comb begin
		ib_eff    = (index_bits_q > IB_MAX) ? IB_MAX : index_bits_q;
		tag_shift = 6'(offset_bits_q) + 6'(ib_eff);
		addr_sh   = req.address >> offset_bits_q;
		set_mask  = ~({SET_BITS{1'b1}} << ib_eff);
		set_in    = addr_sh[SET_BITS-1:0] & set_mask;
		tag_in    = req.address >> tag_shift;
	end

	// captured request
	logic                 is_write_s1;
	logic [SET_BITS-1:0]  set_s1;
	logic [ADDR_BITS-1:0] tag_s1;
	logic                 seen_s1;
	logic [SET_COUNT-1:0] row_seen_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			is_write_s1 <= req.req_type;
			set_s1      <= set_in;
			tag_s1      <= tag_in;
			seen_s1     <= row_seen_q[set_in];
		end
	end

	// a set never written since reset reads as all ways invalid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_seen_q <= '0;
		end else if (cmd.commit) begin
			row_seen_q[set_s1] <= 1'b1;
		end
	end

	sacf_row_t rd_row, cur_row, new_row;
	logic      wr_en;

	sacf_ram #(
		.WIDTH(ROW_BITS),
		.DEPTH(SET_COUNT)
	) u_set_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(set_s1),
		.wr_data(new_row),
		.rd_en  (cmd.capture),
		.rd_addr(set_in),
		.rd_data(rd_row)
	);

	// lookup and fifo fill
	logic [NWAY_BITS-1:0]           nways;
	logic [WAYS-1:0]                in_use;
	logic                           hit;
	logic                           found;
	logic [WAY_BITS-1:0]            first_inv;
	logic [WAYS-1:0][AGE_BITS-1:0]  aged;
	logic [WAY_BITS-1:0]            victim;
	logic [AGE_BITS-1:0]            victim_age;
	logic [WAY_BITS-1:0]            fill_way;

	always_comb begin
		cur_row       = rd_row;
		if (!seen_s1) begin
			cur_row.valid = '0;
		end
		if (ways_used_q == '0) begin
			nways = NWAY_BITS'(1);
		end else if (NWAY_BITS'(ways_used_q) > NWAY_BITS'(WAYS)) begin
			nways = NWAY_BITS'(WAYS);
		end else begin
			nways = NWAY_BITS'(ways_used_q);
		end

		hit       = 1'b0;
		found     = 1'b0;
		first_inv = '0;
		for (int w = 0; w < WAYS; w++) begin
			in_use[w] = NWAY_BITS'(w) < nways;
			if (in_use[w] && cur_row.valid[w] && cur_row.tag[w] == tag_s1) begin
				hit = 1'b1;
			end
			if (in_use[w] && !cur_row.valid[w] && !found) begin
				found     = 1'b1;
				first_inv = WAY_BITS'(w);
			end
		end

		// ways ahead of the first invalid way grow older
		for (int w = 0; w < WAYS; w++) begin
			aged[w] = cur_row.age[w];
			if (in_use[w] && (!found || WAY_BITS'(w) < first_inv) &&
			    cur_row.age[w] != AGE_MAX) begin
				aged[w] = cur_row.age[w] + 1'b1;
			end
		end

		// oldest way, first one on a tie
		victim     = '0;
		victim_age = aged[0];
		for (int w = 1; w < WAYS; w++) begin
			if (in_use[w] && aged[w] > victim_age) begin
				victim     = WAY_BITS'(w);
				victim_age = aged[w];
			end
		end

		fill_way = found ? first_inv : victim;

		new_row                = cur_row;
		new_row.age            = aged;
		new_row.valid[fill_way] = 1'b1;
		new_row.tag[fill_way]   = tag_s1;
		new_row.age[fill_way]   = '0;

		wr_en = cmd.commit && !hit;
	end

	// saturating counters and output register
	logic [COUNT_BITS-1:0] hit_cnt_q, miss_cnt_q, rd_cnt_q, wr_cnt_q;
	logic [COUNT_BITS-1:0] hit_cnt_d, miss_cnt_d, rd_cnt_d, wr_cnt_d;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
		return (c == '1) ? c : c + 1'b1;
	endfunction

	always_comb begin
		hit_cnt_d  = hit ? sat_inc(hit_cnt_q) : hit_cnt_q;
		miss_cnt_d = hit ? miss_cnt_q : sat_inc(miss_cnt_q);
		rd_cnt_d   = hit ? rd_cnt_q : sat_inc(rd_cnt_q);
		wr_cnt_d   = (is_write_s1 == REQ_WRITE) ? sat_inc(wr_cnt_q) : wr_cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
			rd_cnt_q   <= '0;
			wr_cnt_q   <= '0;
		end else if (cmd.commit) begin
			hit_cnt_q  <= hit_cnt_d;
			miss_cnt_q <= miss_cnt_d;
			rd_cnt_q   <= rd_cnt_d;
			wr_cnt_q   <= wr_cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp.hit         <= hit;
			rsp.mem_read    <= !hit;
			rsp.mem_write   <= is_write_s1 == REQ_WRITE;
			rsp.hit_total   <= hit_cnt_d;
			rsp.miss_total  <= miss_cnt_d;
			rsp.read_total  <= rd_cnt_d;
			rsp.write_total <= wr_cnt_d;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/set_assoc_cache_fifo_unit.sv
// top level of the tag-only set-associative cache tracker with fifo replacement
// usage:
//   req channel (req_valid/req_ready/req) takes one access word: read or write
//   of a byte address. rsp channel (rsp_valid/rsp_ready/rsp) returns one word
//   per access: hit, memory read, memory write and the four running counters.
//   cfg channel writes offset_bits (0), index_bits (1), ways_used (2); it is
//   always ready and must only be used while no access is in flight.
// timing:
//   an access is taken in the idle state; the set ram is read with a
//   registered port, and in the lookup state tags are compared, on a miss the
//   set is written back, and the result is loaded into the output register.
//   a new access is taken only after the previous one has left the lookup
//   state, as each makes a single read-then-write pass over the set ram.
// stalls:
//   a waiting result does not block the next accept; the lookup of that next
//   access holds until the output register frees up.
// reset:
//   arst_n clears counters, config to defaults and a per-set seen flag, so
//   every set reads as empty; no clearing pass over the ram is needed.
`default_nettype none
module set_assoc_cache_fifo_unit (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire sacf_pkg::cfg_index_t  cfg_index,
	input  wire logic [4:0]            cfg_data,
	input  wire logic                  req_valid,
	output logic                       req_ready,
	input  wire sacf_pkg::sacf_req_t   req,
	output logic                       rsp_valid,
	input  wire logic                  rsp_ready,
	output sacf_pkg::sacf_rsp_t        rsp
);
	import sacf_pkg::*;

	sacf_cmd_t cmd;

	// config registers live in flops, a write is taken every cycle
	assign cfg_ready = 1'b1;

	sacf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.cmd      (cmd)
	);

	sacf_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req      (req),
		.cmd      (cmd),
		.rsp      (rsp)
	);
endmodule
`default_nettype wire
